### hdl/jtgs_pkg.sv
`timescale 1ns / 1ps

package jtgs_pkg;

	localparam int MAX_USERS_DEF = 1024;
	localparam int MAX_PLACES_DEF = 1024;
	localparam int MAX_USER_TOPICS_DEF = 16;
	localparam int MAX_PLACE_TOPICS_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 20;

	localparam int WEIGHT_WIDTH = 48;
	localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = '1;
	localparam int PRIOR_PRODUCT_WIDTH = 27;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RESAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_USER_TOPICS,
		REG_PLACE_TOPICS,
		REG_ALPHA,
		REG_BETA_USER,
		REG_BETA_PLACE,
		REG_USER_COUNT,
		REG_PLACE_COUNT
	} reg_index_e;

	typedef struct packed {
		logic        command;
		logic [9:0]  user_index;
		logic [9:0]  place_index;
		logic [3:0]  current_user_topic;
		logic [3:0]  current_place_topic;
		logic [31:0] random_draw;
	} record_t;

	typedef struct packed {
		logic [3:0] new_user_topic;
		logic [3:0] new_place_topic;
	} result_t;

	typedef struct packed {
		logic [4:0]  user_topics_in_use;
		logic [4:0]  place_topics_in_use;
		logic [15:0] alpha;
		logic [15:0] beta_user;
		logic [15:0] beta_place;
		logic [10:0] user_count;
		logic [10:0] place_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		user_topics_in_use: 5'd16,
		place_topics_in_use: 5'd16,
		alpha: 16'd256,
		beta_user: 16'd26,
		beta_place: 16'd26,
		user_count: 11'd1024,
		place_count: 11'd1024
	};

	// Width of one weight factor: a count in Q.8 plus a prior or prior product.
	function automatic int factor_width(input int cw);
		return ((cw + 8 > PRIOR_PRODUCT_WIDTH) ? cw + 8 : PRIOR_PRODUCT_WIDTH) + 1;
	endfunction

endpackage

### hdl/jtgs_cfg.sv
`timescale 1ns / 1ps

module jtgs_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output jtgs_pkg::cfg_t   cfg
);
	import jtgs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (reg_index_e'(cfg_index))
				REG_USER_TOPICS: begin
					cfg_q.user_topics_in_use <= cfg_data[4:0];
				end
				REG_PLACE_TOPICS: begin
					cfg_q.place_topics_in_use <= cfg_data[4:0];
				end
				REG_ALPHA: begin
					cfg_q.alpha <= cfg_data;
				end
				REG_BETA_USER: begin
					cfg_q.beta_user <= cfg_data;
				end
				REG_BETA_PLACE: begin
					cfg_q.beta_place <= cfg_data;
				end
				REG_USER_COUNT: begin
					cfg_q.user_count <= cfg_data[10:0];
				end
				REG_PLACE_COUNT: begin
					cfg_q.place_count <= cfg_data[10:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/jtgs_weight.sv
`timescale 1ns / 1ps

module jtgs_weight #(
	parameter int COUNT_WIDTH = jtgs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [jtgs_pkg::factor_width(COUNT_WIDTH)-1:0] f1,
	input  logic [jtgs_pkg::factor_width(COUNT_WIDTH)-1:0] f2,
	input  logic [jtgs_pkg::factor_width(COUNT_WIDTH)-1:0] f3,
	input  logic [jtgs_pkg::factor_width(COUNT_WIDTH)-1:0] d1,
	input  logic [jtgs_pkg::factor_width(COUNT_WIDTH)-1:0] d2,
	output logic                                          done,
	output logic [jtgs_pkg::WEIGHT_WIDTH-1:0]             weight
);
	import jtgs_pkg::*;

	localparam int FW = factor_width(COUNT_WIDTH);
	localparam int WW = WEIGHT_WIDTH;
	localparam int XW = 3 * FW + WW + 1;
	localparam int CNW = $clog2(((FW > WW) ? FW : WW) + 1);

	typedef enum logic [2:0] {
		W_IDLE,
		W_MUL1,
		W_MUL2,
		W_CHK,
		W_DIV
	} wstate_t;

	wstate_t state_q;
	logic [2*FW-1:0] a1_q, p1_q, ad_q, pd_q;
	logic [FW-1:0]   b1_q, bd_q, b2_q;
	logic [3*FW-1:0] a2_q, p2_q;
	logic [XW-1:0]   r_q, y_q;
	logic [WW-1:0]   q_q;
	logic [CNW-1:0]  cnt_q;
	logic            done_q;
	logic [WW-1:0]   w_q;

	logic [2*FW-1:0] p1_next, pd_next;
	logic [3*FW-1:0] p2_next;
	logic [XW-1:0]   num, den_top;
	logic            take;

	assign p1_next = p1_q + (b1_q[0] ? a1_q : '0);
	assign pd_next = pd_q + (bd_q[0] ? ad_q : '0);
	assign p2_next = p2_q + (b2_q[0] ? a2_q : '0);
	assign num = XW'({p2_q, 16'b0});
	assign den_top = XW'(pd_q) << WW;
	assign take = r_q >= y_q;

	assign done = done_q;
	assign weight = w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						a1_q <= (2*FW)'(f1);
						b1_q <= f2;
						p1_q <= '0;
						ad_q <= (2*FW)'(d1);
						bd_q <= d2;
						pd_q <= '0;
						b2_q <= f3;
						p2_q <= '0;
						cnt_q <= '0;
						state_q <= W_MUL1;
					end
				end
				W_MUL1: begin
					p1_q <= p1_next;
					pd_q <= pd_next;
					a1_q <= a1_q << 1;
					ad_q <= ad_q << 1;
					b1_q <= b1_q >> 1;
					bd_q <= bd_q >> 1;
					if (32'(cnt_q) == FW - 1) begin
						a2_q <= (3*FW)'(p1_next);
						cnt_q <= '0;
						state_q <= W_MUL2;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				W_MUL2: begin
					p2_q <= p2_next;
					a2_q <= a2_q << 1;
					b2_q <= b2_q >> 1;
					if (32'(cnt_q) == FW - 1) begin
						cnt_q <= '0;
						state_q <= W_CHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				W_CHK: begin
					if (p2_q == '0) begin
						w_q <= '0;
						done_q <= 1'b1;
						state_q <= W_IDLE;
					end else if (num >= den_top) begin
						w_q <= WEIGHT_MAX;
						done_q <= 1'b1;
						state_q <= W_IDLE;
					end else begin
						r_q <= num;
						y_q <= XW'(pd_q) << (WW - 1);
						q_q <= '0;
						cnt_q <= '0;
						state_q <= W_DIV;
					end
				end
				W_DIV: begin
					if (take) begin
						r_q <= r_q - y_q;
					end
					y_q <= y_q >> 1;
					q_q <= {q_q[WW-2:0], take};
					if (32'(cnt_q) == WW - 1) begin
						w_q <= {q_q[WW-2:0], take};
						done_q <= 1'b1;
						state_q <= W_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/joint_topic_gibbs_sampler.sv
`timescale 1ns / 1ps
// Load item: accepted in IDLE, then PREP, UPD_RD, UPD_WR and OUT; one item at a time.
// Resample item: for each of the C topic pairs in use the bit-serial multiply and
// divide unit forms a weight from factors of width F (29 at the default count
// width), then the cumulative weights are scanned against a threshold from the draw.
// After reset the count memories are cleared, one entry a cycle over the
// deepest table (16384 entries at the defaults), and no item is taken meanwhile.

module joint_topic_gibbs_sampler #(
	parameter int MAX_USERS = jtgs_pkg::MAX_USERS_DEF,
	parameter int MAX_PLACES = jtgs_pkg::MAX_PLACES_DEF,
	parameter int MAX_USER_TOPICS = jtgs_pkg::MAX_USER_TOPICS_DEF,
	parameter int MAX_PLACE_TOPICS = jtgs_pkg::MAX_PLACE_TOPICS_DEF,
	parameter int COUNT_WIDTH = jtgs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                record_valid,
	output logic                record_stall,
	input  jtgs_pkg::record_t   record,
	output logic                result_valid,
	input  logic                result_stall,
	output jtgs_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import jtgs_pkg::*;

	localparam int MUT = MAX_USER_TOPICS;
	localparam int MPT = MAX_PLACE_TOPICS;
	localparam int CW = COUNT_WIDTH;
	localparam int FW = factor_width(CW);
	localparam int WW = WEIGHT_WIDTH;
	localparam int UTW = (MUT > 1) ? $clog2(MUT) : 1;
	localparam int PTW = (MPT > 1) ? $clog2(MPT) : 1;
	localparam int UKW = (UTW > 4) ? UTW : 4;
	localparam int PKW = (PTW > 4) ? PTW : 4;
	localparam int UT_DEPTH = MAX_USERS * MUT;
	localparam int PT_DEPTH = MAX_PLACES * MPT;
	localparam int PR_DEPTH = MUT * MPT;
	localparam int UTAW = (UT_DEPTH > 1) ? $clog2(UT_DEPTH) : 1;
	localparam int PTAW = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
	localparam int PRAW = (PR_DEPTH > 1) ? $clog2(PR_DEPTH) : 1;
	localparam int CLR_A = (UT_DEPTH > PT_DEPTH) ? UT_DEPTH : PT_DEPTH;
	localparam int CLR_DEPTH = (CLR_A > PR_DEPTH) ? CLR_A : PR_DEPTH;
	localparam int CLW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
	localparam logic [CW-1:0] CMAX = '1;

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		PREP,
		UPD_RD,
		UPD_WR,
		W_RD,
		W_LD,
		W_WAIT,
		TH1,
		TH2,
		SC_RD,
		SC_CMP,
		OUT
	} state_t;

	cfg_t cfg;

	state_t           state_q;
	logic [CLW-1:0]   clr_q;
	logic [9:0]       u_q, p_q;
	logic [UKW-1:0]   upd_ku_q;
	logic [PKW-1:0]   upd_kp_q;
	logic             dec_q;
	logic [31:0]      draw_q;
	logic [PRIOR_PRODUCT_WIDTH-1:0] bu_q, bp_q;
	logic [UTW-1:0]   ku_q;
	logic [PTW-1:0]   kp_q;
	logic [PRAW-1:0]  idx_q;
	logic [WW-1:0]    total_q, thr_q;
	logic [63:0]      a_s1;
	logic             out_valid_q;
	result_t          out_q;

	logic [CW-1:0] ut_mem [UT_DEPTH];
	logic [CW-1:0] pt_mem [PT_DEPTH];
	logic [CW-1:0] pr_mem [PR_DEPTH];
	logic [WW-1:0] cum_mem [PR_DEPTH];
	logic [CW-1:0] utot_q [MUT];
	logic [CW-1:0] ptot_q [MPT];

	logic [CW-1:0] ut_rd, pt_rd, pr_rd;
	logic [WW-1:0] cum_rd;
	logic [UTAW-1:0] ut_addr, ubase;
	logic [PTAW-1:0] pt_addr, pbase;
	logic [PRAW-1:0] pr_addr;
	logic ut_we, pt_we, pr_we, cum_we;
	logic [CW-1:0] ut_wd, pt_wd, pr_wd;
	logic upd_vu, upd_vp;
	int nku_i, nkp_i;
	logic last_ku, last_kp;
	logic [FW-1:0] f1, f2, f3, d1, d2;
	logic w_done;
	logic [WW-1:0] w;
	logic [WW:0] sum_w;
	logic [WW-1:0] sum_sat;
	logic [48:0] low_w;
	logic [WW:0] thr_w;

	function automatic logic [CW-1:0] step_count(input logic [CW-1:0] v, input logic down);
		if (down) begin
			return (v == '0) ? '0 : v - 1'b1;
		end
		return (v == CMAX) ? CMAX : v + 1'b1;
	endfunction

	jtgs_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	jtgs_weight #(.COUNT_WIDTH(CW)) u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == W_LD),
		.f1(f1),
		.f2(f2),
		.f3(f3),
		.d1(d1),
		.d2(d2),
		.done(w_done),
		.weight(w)
	);

	always_comb begin
		nku_i = (cfg.user_topics_in_use == '0) ? 1 : 32'(cfg.user_topics_in_use);
		if (nku_i > MUT) begin
			nku_i = MUT;
		end
		nkp_i = (cfg.place_topics_in_use == '0) ? 1 : 32'(cfg.place_topics_in_use);
		if (nkp_i > MPT) begin
			nkp_i = MPT;
		end
	end

	assign last_ku = 32'(ku_q) == nku_i - 1;
	assign last_kp = 32'(kp_q) == nkp_i - 1;

	assign ubase = UTAW'(32'(u_q) * MUT);
	assign pbase = PTAW'(32'(p_q) * MPT);
	assign upd_vu = 32'(upd_ku_q) < MUT;
	assign upd_vp = 32'(upd_kp_q) < MPT;

	always_comb begin
		case (state_q)
			CLEAR: begin
				ut_addr = clr_q[UTAW-1:0];
				pt_addr = clr_q[PTAW-1:0];
				pr_addr = clr_q[PRAW-1:0];
			end
			UPD_RD, UPD_WR: begin
				ut_addr = UTAW'(ubase + UTAW'(upd_ku_q));
				pt_addr = PTAW'(pbase + PTAW'(upd_kp_q));
				pr_addr = PRAW'(32'(upd_ku_q) * MPT + 32'(upd_kp_q));
			end
			default: begin
				ut_addr = UTAW'(ubase + UTAW'(ku_q));
				pt_addr = PTAW'(pbase + PTAW'(kp_q));
				pr_addr = PRAW'(32'(ku_q) * MPT + 32'(kp_q));
			end
		endcase
	end

	always_comb begin
		ut_we = 1'b0;
		pt_we = 1'b0;
		pr_we = 1'b0;
		ut_wd = '0;
		pt_wd = '0;
		pr_wd = '0;
		if (state_q == CLEAR) begin
			ut_we = 32'(clr_q) < UT_DEPTH;
			pt_we = 32'(clr_q) < PT_DEPTH;
			pr_we = 32'(clr_q) < PR_DEPTH;
		end else if (state_q == UPD_WR) begin
			ut_we = upd_vu;
			pt_we = upd_vp;
			pr_we = upd_vu && upd_vp;
			ut_wd = step_count(ut_rd, dec_q);
			pt_wd = step_count(pt_rd, dec_q);
			pr_wd = step_count(pr_rd, dec_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ut_we) begin
			ut_mem[ut_addr] <= ut_wd;
		end
		ut_rd <= ut_mem[ut_addr];
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_addr] <= pt_wd;
		end
		pt_rd <= pt_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (pr_we) begin
			pr_mem[pr_addr] <= pr_wd;
		end
		pr_rd <= pr_mem[pr_addr];
	end

	assign f1 = FW'({pr_rd, 8'b0}) + FW'(cfg.alpha);
	assign f2 = FW'({ut_rd, 8'b0}) + FW'(cfg.beta_user);
	assign f3 = FW'({pt_rd, 8'b0}) + FW'(cfg.beta_place);
	assign d1 = FW'({utot_q[ku_q], 8'b0}) + FW'(bu_q);
	assign d2 = FW'({ptot_q[kp_q], 8'b0}) + FW'(bp_q);

	assign sum_w = {1'b0, total_q} + {1'b0, w};
	assign sum_sat = sum_w[WW] ? WEIGHT_MAX : sum_w[WW-1:0];
	assign cum_we = (state_q == W_WAIT) && w_done;

	always_ff @(posedge clk) begin
		if (cum_we) begin
			cum_mem[idx_q] <= sum_sat;
		end
		cum_rd <= cum_mem[idx_q];
	end

	assign low_w = {1'b0, a_s1[15:0], 32'b0} >> 16;
	assign thr_w = (WW+1)'(a_s1[63:16])
		+ (WW+1)'((low_w + 49'(draw_q) * 49'(total_q[15:0])) >> 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUT; i++) begin
				utot_q[i] <= '0;
			end
			for (int i = 0; i < MPT; i++) begin
				ptot_q[i] <= '0;
			end
		end else if (state_q == UPD_WR) begin
			if (upd_vu) begin
				utot_q[upd_ku_q[UTW-1:0]] <= step_count(utot_q[upd_ku_q[UTW-1:0]], dec_q);
			end
			if (upd_vp) begin
				ptot_q[upd_kp_q[PTW-1:0]] <= step_count(ptot_q[upd_kp_q[PTW-1:0]], dec_q);
			end
		end
	end

	assign record_stall = state_q != IDLE;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			dec_q <= 1'b0;
			ku_q <= '0;
			kp_q <= '0;
			idx_q <= '0;
		end else begin
			if (out_valid_q && !result_stall && state_q != OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					if (32'(clr_q) == CLR_DEPTH - 1) begin
						state_q <= IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				IDLE: begin
					if (record_valid) begin
						u_q <= record.user_index;
						p_q <= record.place_index;
						upd_ku_q <= UKW'(record.current_user_topic);
						upd_kp_q <= PKW'(record.current_place_topic);
						dec_q <= record.command == CMD_RESAMPLE;
						draw_q <= record.random_draw;
						state_q <= PREP;
					end
				end
				PREP: begin
					bu_q <= PRIOR_PRODUCT_WIDTH'(cfg.beta_user)
						* PRIOR_PRODUCT_WIDTH'(cfg.user_count);
					bp_q <= PRIOR_PRODUCT_WIDTH'(cfg.beta_place)
						* PRIOR_PRODUCT_WIDTH'(cfg.place_count);
					if (32'(u_q) >= MAX_USERS) begin
						u_q <= 10'(32'(u_q) - MAX_USERS);
					end
					if (32'(p_q) >= MAX_PLACES) begin
						p_q <= 10'(32'(p_q) - MAX_PLACES);
					end
					if (32'(u_q) < MAX_USERS && 32'(p_q) < MAX_PLACES) begin
						state_q <= UPD_RD;
					end
				end
				UPD_RD: begin
					state_q <= UPD_WR;
				end
				UPD_WR: begin
					if (dec_q) begin
						ku_q <= '0;
						kp_q <= '0;
						idx_q <= '0;
						total_q <= '0;
						state_q <= W_RD;
					end else begin
						state_q <= OUT;
					end
				end
				W_RD: begin
					state_q <= W_LD;
				end
				W_LD: begin
					state_q <= W_WAIT;
				end
				W_WAIT: begin
					if (w_done) begin
						total_q <= sum_sat;
						idx_q <= idx_q + 1'b1;
						if (last_kp) begin
							kp_q <= '0;
							ku_q <= ku_q + 1'b1;
						end else begin
							kp_q <= kp_q + 1'b1;
						end
						if (last_kp && last_ku) begin
							state_q <= TH1;
						end else begin
							state_q <= W_RD;
						end
					end
				end
				TH1: begin
					a_s1 <= 64'(draw_q) * 64'(total_q[WW-1:16]);
					state_q <= TH2;
				end
				TH2: begin
					thr_q <= thr_w[WW-1:0];
					ku_q <= '0;
					kp_q <= '0;
					idx_q <= '0;
					dec_q <= 1'b0;
					if (total_q == '0) begin
						upd_ku_q <= '0;
						upd_kp_q <= '0;
						state_q <= UPD_RD;
					end else begin
						state_q <= SC_RD;
					end
				end
				SC_RD: begin
					state_q <= SC_CMP;
				end
				SC_CMP: begin
					if (cum_rd > thr_q) begin
						upd_ku_q <= UKW'(ku_q);
						upd_kp_q <= PKW'(kp_q);
						state_q <= UPD_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (last_kp) begin
							kp_q <= '0;
							ku_q <= ku_q + 1'b1;
						end else begin
							kp_q <= kp_q + 1'b1;
						end
						state_q <= SC_RD;
					end
				end
				OUT: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						out_q.new_user_topic <= upd_ku_q[3:0];
						out_q.new_place_topic <= upd_kp_q[3:0];
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
